[design/gfr_pkg.sv]
`default_nettype none
package gfr_pkg;

  // default geometry, handed to the top level parameters
  localparam int DISPLAY_WIDTH_DEF  = 128;
  localparam int DISPLAY_HEIGHT_DEF = 64;
  localparam int MAX_SCALE_DEF      = 4;

  localparam int GLYPH_W   = 4;
  localparam int GLYPH_H   = 6;
  localparam int GLYPH_ADV = 5;
  localparam int FONT_SLOTS = 45;

  // item modes
  localparam logic [1:0] MODE_DRAW  = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // one glyph per entry, top row in the high nibble, leftmost pixel in the nibble MSB
  // slot 0 blank, 1..10 digits, 11..36 letters, 37..44 punctuation
  localparam logic [23:0] FONT_ROM [FONT_SLOTS] = '{
    24'h000000,
    24'h699996, 24'h262227, 24'h69124F, 24'hE16196, 24'h26AF22,
    24'hF8E196, 24'h68E996, 24'hF12444, 24'h696996, 24'h699716,
    24'h699F99, 24'hE9E99E, 24'h788887, 24'hE9999E, 24'hF8E88F,
    24'hF8E888, 24'h788B97, 24'h99F999, 24'h722227, 24'h111196,
    24'h9ACA99, 24'h88888F, 24'h9FF999, 24'h9DFB99, 24'h699996,
    24'hE99E88, 24'h6999B7, 24'hE99EA9, 24'h78611E, 24'hF22222,
    24'h999996, 24'h999966, 24'h999FF9, 24'h996699, 24'h996222,
    24'hF1248F,
    24'h000F00, 24'h000006, 24'h000024, 24'h060060, 24'h112244,
    24'h00000F, 24'h002F20, 24'h912892
  };

  // character code to font slot; lower case folds to upper, unknown codes go blank
  function automatic logic [5:0] glyph_slot(input logic [7:0] c);
    logic [7:0] u;
    logic [5:0] slot;
    u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    if (c >= 8'h30 && c <= 8'h39) begin
      slot = 6'd1 + 6'(c - 8'h30);
    end else if (u >= 8'h41 && u <= 8'h5A) begin
      slot = 6'd11 + 6'(u - 8'h41);
    end else begin
      unique case (c)
        8'h2D:   slot = 6'd37;
        8'h2E:   slot = 6'd38;
        8'h2C:   slot = 6'd39;
        8'h3A:   slot = 6'd40;
        8'h2F:   slot = 6'd41;
        8'h5F:   slot = 6'd42;
        8'h2B:   slot = 6'd43;
        8'h25:   slot = 6'd44;
        default: slot = 6'd0;
      endcase
    end
    return slot;
  endfunction

  typedef struct packed {
    logic take;       // input ready
    logic clr_step;   // write zero at the sweep address, advance sweep
    logic draw_init;  // load column/page counters
    logic draw_step;  // read one (column, page) byte, advance counters
    logic rd_item;    // read the byte of a read item
    logic res_load;   // capture the result into the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_mode;
    logic       fit;
    logic       draw_none;
    logic       draw_last;
    logic       clr_last;
    logic       out_free;
  } ctl_sts_t;

endpackage
`default_nettype wire

[design/gfr_if.sv]
`default_nettype none
interface gfr_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [7:0]        char_code;
  logic signed [8:0] x_pos;
  logic signed [7:0] y_pos;
  logic [2:0]        scale;
  logic [7:0]        clip_right;
  logic [9:0]        byte_index;

  modport source (output valid, mode, char_code, x_pos, y_pos, scale, clip_right,
                  byte_index, input ready);
  modport sink   (input valid, mode, char_code, x_pos, y_pos, scale, clip_right,
                  byte_index, output ready);
endinterface

interface gfr_out_if;
  logic              valid;
  logic              ready;
  logic              drawn;
  logic signed [9:0] next_x;
  logic [7:0]        read_data;

  modport source (output valid, drawn, next_x, read_data, input ready);
  modport sink   (input valid, drawn, next_x, read_data, output ready);
endinterface

interface gfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] text_row_offset;

  modport source (output valid, text_row_offset, input ready);
  modport sink   (input valid, text_row_offset, output ready);
endinterface
`default_nettype wire

[design/gfr_ctrl.sv]
`default_nettype none
module gfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  gfr_pkg::ctl_sts_t sts,
  output gfr_pkg::ctl_cmd_t cmd
);
  import gfr_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLR   = 3'd2;
  localparam logic [2:0] S_DSET  = 3'd3;
  localparam logic [2:0] S_DRAW  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_valid) begin
          unique case (sts.in_mode)
            MODE_DRAW:  state_nxt = S_DSET;
            MODE_CLEAR: state_nxt = S_CLR;
            MODE_READ:  state_nxt = S_READ;
            MODE_NONE:  state_nxt = S_FIN;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_FIN;
      end
      S_DSET: begin
        if (!sts.fit || sts.draw_none) begin
          state_nxt = S_FIN;
        end else begin
          cmd.draw_init = 1'b1;
          state_nxt     = S_DRAW;
        end
      end
      S_DRAW: begin
        cmd.draw_step = 1'b1;
        if (sts.draw_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_FIN;   // last write-back lands here
      S_READ: begin
        cmd.rd_item = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && sts.in_valid) |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");
`endif

endmodule
`default_nettype wire

[design/gfr_dpath.sv]
`default_nettype none
module gfr_dpath #(
  parameter int DISPLAY_WIDTH  = gfr_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = gfr_pkg::DISPLAY_HEIGHT_DEF,
  parameter int MAX_SCALE      = gfr_pkg::MAX_SCALE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  gfr_in_if.sink            in_ch,
  gfr_out_if.source         out_ch,
  gfr_cfg_if.sink           cfg_ch,
  input  gfr_pkg::ctl_cmd_t cmd,
  output gfr_pkg::ctl_sts_t sts
);
  import gfr_pkg::*;

  localparam int PAGES       = DISPLAY_HEIGHT / 8;
  localparam int STORE_BYTES = DISPLAY_WIDTH * PAGES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int EW          = GLYPH_H * MAX_SCALE;        // tallest scaled column
  localparam int SHW         = $clog2(EW + 8);
  localparam int SW          = $clog2(MAX_SCALE + 1);
  localparam int CW          = $clog2(GLYPH_W * MAX_SCALE);
  localparam int DXW         = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int PW          = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam logic signed [11:0] W12 = 12'(DISPLAY_WIDTH);
  localparam logic signed [11:0] H12 = 12'(DISPLAY_HEIGHT);

  // config
  logic [2:0] tro_r;

  // item registers
  logic [1:0]        mode_r;
  logic signed [8:0] x_r;
  logic signed [9:0] y_r;       // y_pos plus row offset
  logic [SW-1:0]     s_r;       // clamped scale
  logic [7:0]        clip_r;
  logic [9:0]        idx_r;
  logic [23:0]       glyph_r;

  // walk counters
  logic [CW-1:0]  cc_r;         // cell column 0..4s-1
  logic [1:0]     gc_r;         // glyph column
  logic [DXW-1:0] dx_r;         // replica within glyph column
  logic [PW-1:0]  pg_r;
  logic [AW-1:0]  clr_a_r;

  // write-back stage and memory
  logic           wr1_v_r;
  logic [AW-1:0]  wr1_a_r;
  logic [7:0]     wr1_m_r;
  logic [7:0]     mem_q_r;
  logic [7:0]     mem [STORE_BYTES];

  // output register
  logic              out_valid_r;
  logic              drawn_r;
  logic signed [9:0] next_x_r;
  logic [7:0]        rdata_r;

  logic              acc;
  logic [3:0]        sc_in;
  logic [SW-1:0]     s_in;
  logic signed [11:0] x12, y12, s12, clip12, s4, s5, s6, row_hi, px12, cc12, dx12, pg12;
  logic signed [11:0] sh12, y_sh, rh_sh;
  logic              fit, draw_none, col_ok, pg_last, dx_last, draw_last, clr_last;
  logic [PW-1:0]     first_pg, last_pg;
  logic [AW-1:0]     step_addr, rd_addr, wr_addr;
  logic              rd_en, wr_en, in_range;
  logic [7:0]        wr_data, byte_m;
  logic [GLYPH_W-1:0] nib_a [GLYPH_H];
  logic [GLYPH_H-1:0] col6;
  logic [EW-1:0]     ecol;
  logic [EW+7:0]     pshift;

  assign acc = cmd.take & in_ch.valid;
  assign in_ch.ready  = cmd.take;
  assign cfg_ch.ready = 1'b1;

  // scale clamp: 0 acts as 1, above the maximum saturates
  always_comb begin
    sc_in = {1'b0, in_ch.scale};
    if (sc_in == 4'd0) begin
      s_in = SW'(1);
    end else if (sc_in > 4'(MAX_SCALE)) begin
      s_in = SW'(MAX_SCALE);
    end else begin
      s_in = SW'(sc_in);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tro_r <= 3'd1;
    end else if (cfg_ch.valid) begin
      tro_r <= cfg_ch.text_row_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mode_r  <= in_ch.mode;
      x_r     <= in_ch.x_pos;
      y_r     <= {{2{in_ch.y_pos[7]}}, in_ch.y_pos} + {7'd0, tro_r};
      s_r     <= s_in;
      clip_r  <= in_ch.clip_right;
      idx_r   <= in_ch.byte_index;
      glyph_r <= FONT_ROM[glyph_slot(in_ch.char_code)];
    end
  end

  // geometry of the current item
  always_comb begin
    x12    = {{3{x_r[8]}}, x_r};
    y12    = {{2{y_r[9]}}, y_r};
    s12    = {{(12-SW){1'b0}}, s_r};
    clip12 = {4'd0, clip_r};
    s4     = s12 <<< 2;
    s5     = s4 + s12;
    s6     = s4 + (s12 <<< 1);
    fit    = ((x12 + s4) <= clip12) && ((x12 + s4) <= W12);
    row_hi = y12 + s6 - 12'sd1;
    draw_none = (row_hi < 12'sd0) || (y12 >= H12);
    y_sh   = y12 >>> 3;
    rh_sh  = row_hi >>> 3;
    first_pg = (y12 < 12'sd0) ? '0 : y_sh[PW-1:0];
    last_pg  = (row_hi >= H12) ? PW'(PAGES - 1) : rh_sh[PW-1:0];
  end

  // current (column, page) byte
  always_comb begin
    cc12 = {{(12-CW){1'b0}}, cc_r};
    dx12 = {{(12-DXW){1'b0}}, dx_r};
    pg12 = {{(12-PW){1'b0}}, pg_r};
    px12 = x12 + cc12;
    col_ok    = (px12 >= 12'sd0) && (px12 < W12);
    step_addr = AW'(px12) + AW'(pg_r) * AW'(DISPLAY_WIDTH);
    pg_last   = (pg_r == last_pg);
    dx_last   = (dx12 == s12 - 12'sd1);
    draw_last = pg_last && (cc12 == s4 - 12'sd1);
    // byte bit b shows scaled row (page*8 + b - y)
    sh12 = 12'sd8 + (pg12 <<< 3) - y12;
  end

  // glyph column, replicated vertically by the scale
  always_comb begin
    ecol = '0;
    for (int r = 0; r < GLYPH_H; r++) begin
      nib_a[r] = glyph_r[(GLYPH_H-1-r)*GLYPH_W +: GLYPH_W];
      col6[r]  = nib_a[r][~gc_r];
    end
    for (int sc = 1; sc <= MAX_SCALE; sc++) begin
      for (int r = 0; r < GLYPH_H; r++) begin
        for (int d = 0; d < sc; d++) begin
          if (s_r == SW'(sc)) ecol[r*sc + d] = col6[r];
        end
      end
    end
    pshift = {ecol, 8'd0} >> sh12[SHW-1:0];
    byte_m = pshift[7:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_init) begin
      cc_r <= '0;
      gc_r <= '0;
      dx_r <= '0;
      pg_r <= first_pg;
    end else if (cmd.draw_step) begin
      if (pg_last) begin
        pg_r <= first_pg;
        cc_r <= cc_r + 1'b1;
        if (dx_last) begin
          dx_r <= '0;
          gc_r <= gc_r + 1'b1;
        end else begin
          dx_r <= dx_r + 1'b1;
        end
      end else begin
        pg_r <= pg_r + 1'b1;
      end
    end
  end

  assign clr_last = (clr_a_r == AW'(STORE_BYTES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_a_r <= '0;
      wr1_v_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_a_r <= clr_last ? '0 : clr_a_r + 1'b1;
      wr1_v_r <= cmd.draw_step & col_ok;
    end
  end

  always_ff @(posedge clk) begin
    wr1_a_r <= step_addr;
    wr1_m_r <= byte_m;
  end

  // one write port, one registered read port
  assign rd_en   = cmd.draw_step | cmd.rd_item;
  assign rd_addr = cmd.rd_item ? AW'(idx_r) : step_addr;
  assign wr_en   = cmd.clr_step | wr1_v_r;
  assign wr_addr = cmd.clr_step ? clr_a_r : wr1_a_r;
  assign wr_data = cmd.clr_step ? 8'd0 : (mem_q_r | wr1_m_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q_r <= mem[rd_addr];
  end

  assign in_range = (32'(idx_r) < 32'(STORE_BYTES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      drawn_r  <= (mode_r == MODE_DRAW) && fit;
      next_x_r <= (mode_r != MODE_DRAW) ? 10'sd0 :
                  fit ? 10'(x12 + s5) : {x_r[8], x_r};
      rdata_r  <= ((mode_r == MODE_READ) && in_range) ? mem_q_r : 8'd0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.drawn     = drawn_r;
  assign out_ch.next_x    = next_x_r;
  assign out_ch.read_data = rdata_r;

  always_comb begin
    sts.in_valid  = in_ch.valid;
    sts.in_mode   = in_ch.mode;
    sts.fit       = fit;
    sts.draw_none = draw_none;
    sts.draw_last = draw_last;
    sts.clr_last  = clr_last;
    sts.out_free  = !out_valid_r || out_ch.ready;
  end

`ifndef SYNTHESIS
  a_wb_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    wr1_v_r |-> $past(cmd.draw_step))
    else $error("write-back without a draw read");
  a_page_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.draw_step |-> (pg_r >= first_pg && pg_r <= last_pg))
    else $error("draw page outside glyph span");
  a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_step && wr1_v_r))
    else $error("clear sweep and draw write-back collide");
`endif

endmodule
`default_nettype wire

[design/glyph_framebuffer_renderer_top.sv]
`default_nettype none
// Glyph framebuffer renderer: a 4x6 bitmap character generator over a page-layout
// monochrome framebuffer (pixel (x,y) is bit y%8 of byte x + (y/8)*DISPLAY_WIDTH),
// held in an on-chip RAM of DISPLAY_WIDTH*DISPLAY_HEIGHT/8 bytes. Items arrive on
// in_chan, one result per item leaves on out_chan. Draw (mode 0) ORs a scaled glyph
// in at (x_pos, y_pos + text_row_offset) and reports drawn/next_x; a glyph whose
// cell runs past clip_right or the right display edge is refused and leaves the
// store unchanged. Clear (mode 1) zeroes the store; read (mode 2) returns one byte.
// Timing: a draw walks every (cell column, touched page) pair with one pipelined
// read-modify-write per cycle on the single RAM; touched pages are the on-screen
// 8-row bands the scaled glyph touches, at most 4 for scale 4. Columns left of the
// screen are still walked, so a glyph that fits but lies wholly off the left side
// costs the full walk. A refused glyph, or one wholly above or below the screen,
// skips the walk. Clear is a sweep of one byte per cycle. After reset the same
// sweep clears the RAM: no item is accepted until it ends. One item is in work at
// a time; the result sits in an output register, so the next item is taken while
// it waits. cfg_chan is always ready and should only be written while no item is
// in flight.
module glyph_framebuffer_renderer_top #(
  parameter int DISPLAY_WIDTH  = gfr_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = gfr_pkg::DISPLAY_HEIGHT_DEF,
  parameter int MAX_SCALE      = gfr_pkg::MAX_SCALE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gfr_in_if.sink    in_chan,
  gfr_out_if.source out_chan,
  gfr_cfg_if.sink   cfg_chan
);
  import gfr_pkg::*;

  ctl_cmd_t cmd;   // controller -> datapath
  ctl_sts_t sts;   // datapath -> controller

  // sequencer: reset sweep, dispatch by mode, draw walk, result hand-off
  gfr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // item registers, walk counters, RAM with write-back stage, output register
  gfr_dpath #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .MAX_SCALE      (MAX_SCALE)
  ) u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_chan),
    .out_ch (out_chan),
    .cfg_ch (cfg_chan),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
`default_nettype wire
